// ----- sv/cds_pkg.sv -----
// ---------------------------------------------------------------------------
// cds_pkg: shared types and constants
// Field widths, operation and status codes, and the distance unit's
// request/response structs for the cyclic distance spectrum block.
// ---------------------------------------------------------------------------
`default_nettype none

package cds_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 14;
   localparam int DIST_W   = 14;
   localparam int CFG_W    = 15;
   localparam int COEF_W   = 3;
   localparam int STORED_W = 9;
   localparam int STATUS_W = 2;

   localparam logic [CFG_W-1:0]  LENGTH_RESET = 15'd16384;
   localparam logic [COEF_W-1:0] COUNT_SAT    = 3'd4;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_DUP   = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic             start;
      logic [POS_W-1:0] pos_a;
      logic [POS_W-1:0] pos_b;
      logic [CFG_W-1:0] length;
   } dist_req_type;

   typedef struct packed {
      logic              skip;
      logic [DIST_W-1:0] gap;
   } dist_rsp_type;

endpackage

`default_nettype wire

// ----- sv/cds_if.sv -----
// ---------------------------------------------------------------------------
// cds_if: channel interfaces
// Request, response and register-write channels, each a valid/ready beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface cds_req_if;
   logic                         valid;
   logic                         ready;
   logic [cds_pkg::OP_W-1:0]     operation;
   logic [cds_pkg::POS_W-1:0]    position;
   logic [cds_pkg::DIST_W-1:0]   distance;

   modport source (output valid, output operation, output position, output distance,
                   input ready);
   modport sink   (input valid, input operation, input position, input distance,
                   output ready);
endinterface

interface cds_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cds_pkg::COEF_W-1:0]     coefficient;
   logic [cds_pkg::STORED_W-1:0]   stored_count;
   logic [cds_pkg::STATUS_W-1:0]   status;

   modport source (output valid, output coefficient, output stored_count, output status,
                   input ready);
   modport sink   (input valid, input coefficient, input stored_count, input status,
                   output ready);
endinterface

interface cds_csr_if;
   logic                        valid;
   logic                        ready;
   logic [cds_pkg::CFG_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/cds_ram.sv -----
// ---------------------------------------------------------------------------
// cds_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cds_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- sv/cds_dist_unit.sv -----
// ---------------------------------------------------------------------------
// cds_dist_unit: cyclic distance unit
// Registered min(|a-b|, p-|a-b|), flags a stored position outside the block.
// ---------------------------------------------------------------------------
`default_nettype none

module cds_dist_unit (
   input  wire logic                  clock,
   input  wire cds_pkg::dist_req_type du_req,
   output cds_pkg::dist_rsp_type      du_rsp
);

   logic [cds_pkg::POS_W-1:0]  diff;
   logic [cds_pkg::CFG_W-1:0]  alt;
   logic [cds_pkg::DIST_W-1:0] gap;
   logic                       skip;
   cds_pkg::dist_rsp_type      rsp_ff;

   always_comb begin
      diff = (du_req.pos_a > du_req.pos_b) ? du_req.pos_a - du_req.pos_b
                                           : du_req.pos_b - du_req.pos_a;
      alt  = du_req.length - {1'b0, diff};
      // alt only wins when below diff, so it fits the distance width then
      gap  = ({1'b0, diff} <= alt) ? diff : alt[cds_pkg::DIST_W-1:0];
      skip = ({1'b0, du_req.pos_b} >= du_req.length);
   end

   always_ff @(posedge clock) begin
      if (du_req.start) begin
         rsp_ff.gap  <= gap;
         rsp_ff.skip <= skip;
      end
   end

   assign du_rsp = rsp_ff;

endmodule

`default_nettype wire

// ----- sv/cyclic_distance_spectrum_top.sv -----
// ---------------------------------------------------------------------------
// cyclic_distance_spectrum_top: distance spectrum of a sparse cyclic block
// Sequencer around a position store, a spectrum counter RAM and one
// shared cyclic distance unit.
// ---------------------------------------------------------------------------
// One beat in, one beat out per operation. A read issues one counter RAM read
// and then responds; an add of a valid new position first scans the n stored
// positions for a duplicate, one entry per cycle, then for each stored position
// does a read-modify-write of a spectrum counter through the counter RAM and
// the shared distance unit (states PLOAD, PREAD, PWRITE); a rejected add ends
// after the scan or at once. A clear, and the state after reset, runs a sweep
// over all MAX_LENGTH/2 counters, one per cycle, during which no request is
// taken; register writes are taken at any time. A finished result waits in an
// output register, so the next request can start before the previous response
// beat is taken.
`default_nettype none

module cyclic_distance_spectrum_top #(
   parameter int MAX_LENGTH = 16384,
   parameter int MAX_WEIGHT = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cds_req_if.sink    req_chan,
   cds_rsp_if.source  rsp_chan,
   cds_csr_if.sink    csr_chan
);

   localparam int CNT_DEPTH = MAX_LENGTH / 2;
   localparam int CNT_AW    = $clog2(CNT_DEPTH);
   localparam int WAW       = $clog2(MAX_WEIGHT);
   localparam int NUM_W     = $clog2(MAX_WEIGHT + 1);
   localparam logic [cds_pkg::CFG_W-1:0] LEN_RESET =
      (MAX_LENGTH < 16384) ? cds_pkg::CFG_W'(MAX_LENGTH) : cds_pkg::LENGTH_RESET;

   typedef enum logic [7:0] {
      S_SWEEP  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_PLOAD  = 8'b0000_1000,
      S_PREAD  = 8'b0001_0000,
      S_PWRITE = 8'b0010_0000,
      S_RDWAIT = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type                      state_ff, state_in;
   logic [cds_pkg::CFG_W-1:0]      len_ff, len_in;
   logic [cds_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [NUM_W-1:0]               count_ff, count_in;
   logic [NUM_W-1:0]               scan_ff, scan_in;
   logic                           chk_ff, chk_in;
   logic [NUM_W-1:0]               k_ff, k_in;
   logic [CNT_AW-1:0]              sweep_ff, sweep_in;
   logic                           sweep_rsp_ff, sweep_rsp_in;
   cds_pkg::status_type            res_status_ff, res_status_in;
   logic [cds_pkg::COEF_W-1:0]     res_coef_ff, res_coef_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [cds_pkg::COEF_W-1:0]     rsp_coef_ff, rsp_coef_in;
   logic [cds_pkg::STORED_W-1:0]   rsp_count_ff, rsp_count_in;
   cds_pkg::status_type            rsp_status_ff, rsp_status_in;

   logic                           req_acc;
   cds_pkg::op_type                req_op;
   logic [cds_pkg::CFG_W-1:0]      csr_len;
   logic [cds_pkg::DIST_W-1:0]     half_len;
   logic                           read_bad;
   logic [CNT_AW-1:0]              pair_addr;

   logic                           pst_we, pst_re;
   logic [WAW-1:0]                 pst_wa, pst_ra;
   logic [cds_pkg::POS_W-1:0]      pst_wd, pst_q;
   logic                           cnt_we, cnt_re;
   logic [CNT_AW-1:0]              cnt_wa, cnt_ra;
   logic [cds_pkg::COEF_W-1:0]     cnt_wd, cnt_q;

   cds_pkg::dist_req_type          du_req;
   cds_pkg::dist_rsp_type          du_rsp;

   cds_ram #(.WIDTH(cds_pkg::POS_W), .DEPTH(MAX_WEIGHT)) u_pos_store (
      .clock   (clock),
      .wr_en   (pst_we),
      .wr_addr (pst_wa),
      .wr_data (pst_wd),
      .rd_en   (pst_re),
      .rd_addr (pst_ra),
      .rd_data (pst_q)
   );

   cds_ram #(.WIDTH(cds_pkg::COEF_W), .DEPTH(CNT_DEPTH)) u_spectrum (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wa),
      .wr_data (cnt_wd),
      .rd_en   (cnt_re),
      .rd_addr (cnt_ra),
      .rd_data (cnt_q)
   );

   cds_dist_unit u_dist (
      .clock  (clock),
      .du_req (du_req),
      .du_rsp (du_rsp)
   );

   assign req_acc        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_op         = cds_pkg::op_type'(req_chan.operation);

   assign csr_chan.ready = 1'b1;
   // lengths beyond the store limit act as the limit
   assign csr_len = (32'(csr_chan.data) > MAX_LENGTH) ? cds_pkg::CFG_W'(MAX_LENGTH)
                                                      : csr_chan.data;
   assign len_in  = (csr_chan.valid && csr_chan.ready) ? csr_len : len_ff;

   assign half_len  = len_ff[cds_pkg::CFG_W-1:1];
   assign read_bad  = (req_chan.distance == '0) || (req_chan.distance > half_len) ||
                      (32'(req_chan.distance) > CNT_DEPTH);
   assign pair_addr = CNT_AW'(du_rsp.gap - cds_pkg::DIST_W'(1));

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.coefficient  = rsp_coef_ff;
   assign rsp_chan.stored_count = rsp_count_ff;
   assign rsp_chan.status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      k_in          = k_ff;
      sweep_in      = sweep_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      res_status_in = res_status_ff;
      res_coef_in   = res_coef_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_coef_in   = rsp_coef_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      pst_we = 1'b0;
      pst_wa = count_ff[WAW-1:0];
      pst_wd = pos_ff;
      pst_re = 1'b0;
      pst_ra = '0;
      cnt_we = 1'b0;
      cnt_wa = sweep_ff;
      cnt_wd = '0;
      cnt_re = 1'b0;
      cnt_ra = '0;

      du_req.start  = 1'b0;
      du_req.pos_a  = pos_ff;
      du_req.pos_b  = pst_q;
      du_req.length = len_ff;

      if (rsp_vld_ff && rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         S_SWEEP: begin
            cnt_we   = 1'b1;
            cnt_wa   = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CNT_AW'(CNT_DEPTH - 1)) begin
               sweep_in     = '0;
               sweep_rsp_in = 1'b0;
               state_in     = sweep_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               pos_in        = req_chan.position;
               res_coef_in   = '0;
               res_status_in = cds_pkg::ST_OK;
               unique case (req_op)
                  cds_pkg::OP_CLEAR: begin
                     count_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  cds_pkg::OP_ADD: begin
                     if ({1'b0, req_chan.position} >= len_ff) begin
                        res_status_in = cds_pkg::ST_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        scan_in  = '0;
                        chk_in   = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  cds_pkg::OP_READ: begin
                     if (read_bad) begin
                        res_status_in = cds_pkg::ST_RANGE;
                        state_in      = S_DONE;
                     end else begin
                        cnt_re   = 1'b1;
                        cnt_ra   = CNT_AW'(req_chan.distance - cds_pkg::DIST_W'(1));
                        state_in = S_RDWAIT;
                     end
                  end
                  default: begin
                     res_status_in = cds_pkg::ST_RANGE;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one store read issued per cycle, compared the cycle after
            if (chk_ff && (pst_q == pos_ff)) begin
               res_status_in = cds_pkg::ST_DUP;
               state_in      = S_DONE;
            end else if (scan_ff < count_ff) begin
               pst_re  = 1'b1;
               pst_ra  = scan_ff[WAW-1:0];
               scan_in = scan_ff + 1'b1;
               chk_in  = 1'b1;
            end else if (chk_ff) begin
               chk_in = 1'b0;
            end else if (count_ff == NUM_W'(MAX_WEIGHT)) begin
               res_status_in = cds_pkg::ST_FULL;
               state_in      = S_DONE;
            end else if (count_ff == '0) begin
               pst_we   = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               pst_re   = 1'b1;
               pst_ra   = '0;
               k_in     = '0;
               state_in = S_PLOAD;
            end
         end
         S_PLOAD: begin
            du_req.start = 1'b1;
            state_in     = S_PREAD;
         end
         S_PREAD: begin
            cnt_re   = !du_rsp.skip;
            cnt_ra   = pair_addr;
            state_in = S_PWRITE;
         end
         S_PWRITE: begin
            if (!du_rsp.skip && (cnt_q < cds_pkg::COUNT_SAT)) begin
               cnt_we = 1'b1;
               cnt_wa = pair_addr;
               cnt_wd = cnt_q + 1'b1;
            end
            k_in = k_ff + 1'b1;
            if (k_in == count_ff) begin
               pst_we   = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end else begin
               pst_re   = 1'b1;
               pst_ra   = k_in[WAW-1:0];
               state_in = S_PLOAD;
            end
         end
         S_RDWAIT: begin
            res_coef_in = cnt_q;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_coef_in   = res_coef_ff;
               rsp_count_in  = cds_pkg::STORED_W'(count_ff);
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         len_ff       <= LEN_RESET;
         count_ff     <= '0;
         scan_ff      <= '0;
         chk_ff       <= 1'b0;
         k_ff         <= '0;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         chk_ff       <= chk_in;
         k_ff         <= k_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      res_status_ff <= res_status_in;
      res_coef_ff   <= res_coef_in;
      rsp_coef_ff   <= rsp_coef_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NUM_W'(MAX_WEIGHT))
      else $error("stored position count above store depth");

   a_counter_sat: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (cnt_wd <= cds_pkg::COUNT_SAT))
      else $error("spectrum counter written above saturation");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ($past(state_ff) == S_IDLE || $past(state_ff) == S_SCAN ||
          $past(state_ff) == S_PWRITE))
      else $error("stored count changed outside clear or add");
`endif

endmodule

`default_nettype wire
